FILE: rtl/dmrsc_pkg.sv
// shared types, codes and tables for the dual motor ramp and steer controller
package dmrsc_pkg;

  // command modes
  localparam logic [2:0] MODE_STRAIGHT = 3'd0;
  localparam logic [2:0] MODE_LEFT     = 3'd1;
  localparam logic [2:0] MODE_RIGHT    = 3'd2;
  localparam logic [2:0] MODE_BACK     = 3'd3;
  localparam logic [2:0] MODE_WAIT     = 3'd4;

  // register indexes on the configuration port
  localparam logic [2:0] REG_RAMP_INTERVAL = 3'd0;
  localparam logic [2:0] REG_MIN_SPEED     = 3'd1;
  localparam logic [2:0] REG_STEP_STRAIGHT = 3'd2;
  localparam logic [2:0] REG_STEP_ROTATE   = 3'd3;
  localparam logic [2:0] REG_STEP_BACK     = 3'd4;
  localparam logic [2:0] REG_SPEED_DIV     = 3'd5;

  // register reset values
  localparam logic [15:0] RAMP_INTERVAL_RST = 16'd20;
  localparam logic [7:0]  MIN_SPEED_RST     = 8'd0;
  localparam logic [7:0]  STEP_RST          = 8'd5;
  localparam logic [7:0]  SPEED_DIV_RST     = 8'd1;

  // speed and delta knee below which no wheel is slowed
  localparam logic [7:0] SLOW_KNEE = 8'd10;

  // shared divider operand width
  localparam int DIV_W = 12;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

  // bridge direction bits {right_in1, right_in2, left_in1, left_in2}
  function automatic logic [3:0] dir_bits(input logic [1:0] mode);
    logic [3:0] bits;
    case (mode)
      MODE_STRAIGHT[1:0]: bits = 4'b1001;
      MODE_LEFT[1:0]:     bits = 4'b0101;
      MODE_RIGHT[1:0]:    bits = 4'b1010;
      default:            bits = 4'b0110;
    endcase
    return bits;
  endfunction

endpackage

FILE: rtl/dmrsc_div.sv
// restoring unsigned divider, one quotient bit per cycle
module dmrsc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  dmrsc_pkg::div_req_t req,
  output dmrsc_pkg::div_rsp_t rsp
);

  localparam int W    = dmrsc_pkg::DIV_W;
  localparam int CntW = $clog2(W);
  localparam logic [CntW-1:0] LastStep = CntW'(W - 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]    rem_r, rem_nxt;
  logic [W-1:0]    quo_r, quo_nxt;
  logic [W-1:0]    den_r, den_nxt;
  logic [W:0]      rem_shift;
  logic [W:0]      trial;

  // one shift and trial subtract per step
  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    rem_shift = {rem_r, quo_r[W-1]};
    trial     = rem_shift - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LastStep) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: rtl/dual_motor_ramp_steer_controller_core.sv
// Dual motor ramp and steer controller: command sequencer over one shared divider.
// Mode entry, idle or plain ramp commands pass EVAL, PINS and OUT after accept, wait or unknown modes
// pass EVAL and OUT; a slowed back ramp adds DIVA, DIVB and APPLY before PINS, and a slowed straight ramp
// adds DIVC as well, running the shared divider twice or three times in series respectively.
// Throughput: one command at a time; in_tready rises with out_tvalid.
// Reset: rst_n synchronous active low; clears registers to defaults, ramp state and outputs.
module dual_motor_ramp_steer_controller_core #(
  parameter int PWM_BITS = 8,
  localparam int OutW = ((5 + 2 * PWM_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  // command stream
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [55:0]     in_tdata,    // target_speed[7:0], steer_delta[16:8], now_ms[48:17]
  input  logic [2:0]      in_tuser,    // req_type[2:0]
  // result stream
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [OutW-1:0] out_tdata,   // motors_enabled, right_in1, right_in2, left_in1,
                                       // left_in2, right_pwm, left_pwm
  // configuration port
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [4:0]      cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);

  localparam int W = dmrsc_pkg::DIV_W;
  localparam logic [16:0] PwmMaxW = 17'((1 << PWM_BITS) - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_DIVA, S_DIVB, S_DIVC, S_APPLY, S_PINS, S_OUT
  } state_t;

  // configuration registers
  logic [15:0] ramp_interval_r;
  logic [7:0]  min_speed_r;
  logic [7:0]  step_straight_r;
  logic [7:0]  step_rotate_r;
  logic [7:0]  step_back_r;
  logic [7:0]  speed_div_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_interval_r <= dmrsc_pkg::RAMP_INTERVAL_RST;
      min_speed_r     <= dmrsc_pkg::MIN_SPEED_RST;
      step_straight_r <= dmrsc_pkg::STEP_RST;
      step_rotate_r   <= dmrsc_pkg::STEP_RST;
      step_back_r     <= dmrsc_pkg::STEP_RST;
      speed_div_r     <= dmrsc_pkg::SPEED_DIV_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dmrsc_pkg::REG_RAMP_INTERVAL: ramp_interval_r <= cfg_pwdata[15:0];
        dmrsc_pkg::REG_MIN_SPEED:     min_speed_r     <= cfg_pwdata[7:0];
        dmrsc_pkg::REG_STEP_STRAIGHT: step_straight_r <= cfg_pwdata[7:0];
        dmrsc_pkg::REG_STEP_ROTATE:   step_rotate_r   <= cfg_pwdata[7:0];
        dmrsc_pkg::REG_STEP_BACK:     step_back_r     <= cfg_pwdata[7:0];
        dmrsc_pkg::REG_SPEED_DIV:     speed_div_r     <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_idx)
      dmrsc_pkg::REG_RAMP_INTERVAL: cfg_prdata = {16'd0, ramp_interval_r};
      dmrsc_pkg::REG_MIN_SPEED:     cfg_prdata = {24'd0, min_speed_r};
      dmrsc_pkg::REG_STEP_STRAIGHT: cfg_prdata = {24'd0, step_straight_r};
      dmrsc_pkg::REG_STEP_ROTATE:   cfg_prdata = {24'd0, step_rotate_r};
      dmrsc_pkg::REG_STEP_BACK:     cfg_prdata = {24'd0, step_back_r};
      dmrsc_pkg::REG_SPEED_DIV:     cfg_prdata = {24'd0, speed_div_r};
      default:                      cfg_prdata = '0;
    endcase
  end

  // sequencer and ramp state
  state_t             state_r, state_nxt;
  logic [3:0]         mode_started_r, mode_started_nxt;
  logic signed [15:0] lvl1_r, lvl1_nxt;
  logic signed [15:0] lvl2_r, lvl2_nxt;
  logic [31:0]        last_ramp_r, last_ramp_nxt;
  logic [3:0]         pin_dir_r, pin_dir_nxt;
  logic [7:0]         pin_rpwm_r, pin_rpwm_nxt;
  logic [7:0]         pin_lpwm_r, pin_lpwm_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [OutW-1:0]    out_tdata_r, out_tdata_nxt;
  logic               div_start_r, div_start_nxt;

  // captured command and intermediate values
  logic [2:0]         mode_r, mode_nxt;
  logic [7:0]         speed_r, speed_nxt;
  logic [8:0]         delta_r, delta_nxt;
  logic [31:0]        now_r, now_nxt;
  logic               enabled_r, enabled_nxt;
  logic [W-1:0]       div_num_r, div_num_nxt;
  logic [W-1:0]       div_den_r, div_den_nxt;
  logic [7:0]         stdiv_r, stdiv_nxt;
  logic [7:0]         red_r, red_nxt;

  dmrsc_pkg::div_req_t div_req;
  dmrsc_pkg::div_rsp_t div_rsp;

  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_num_r;
  assign div_req.divisor  = div_den_r;

  dmrsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic signed [15:0] smin(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    return (a < b) ? a : b;
  endfunction

  // clamp a level to the pwm range, keep the low byte that the pins carry
  function automatic logic [7:0] sat_pwm(input logic signed [15:0] v);
    logic signed [16:0] vx;
    logic [7:0]         res;
    vx = {v[15], v};
    if (v < 0) res = 8'd0;
    else if (vx > $signed(PwmMaxW)) res = PwmMaxW[7:0];
    else res = v[7:0];
    return res;
  endfunction

  // decoded command values
  logic        mode_ok, rotate, straight, delta_neg, delta_zero, ramp_due, use_slow;
  logic [1:0]  mode_idx;
  logic [8:0]  d_abs;
  logic [7:0]  dm10, step_sel, sd_eff, cap;
  logic [W-1:0] num_a, den_a;
  logic signed [15:0] speed_s, cap_s, capd_s, st_s, stdiv_s, r_lvl, l_lvl;
  logic [OutW-1:0] out_word;

  always_comb begin
    mode_ok    = (mode_r < dmrsc_pkg::MODE_WAIT);
    mode_idx   = mode_r[1:0];
    rotate     = (mode_r == dmrsc_pkg::MODE_LEFT) || (mode_r == dmrsc_pkg::MODE_RIGHT);
    straight   = (mode_r == dmrsc_pkg::MODE_STRAIGHT);
    delta_neg  = delta_r[8];
    delta_zero = (delta_r == 9'd0);
    d_abs      = delta_neg ? (~delta_r + 9'd1) : delta_r;
    ramp_due   = ((now_r - last_ramp_r) >= {16'd0, ramp_interval_r});
    case (mode_r)
      dmrsc_pkg::MODE_STRAIGHT: step_sel = step_straight_r;
      dmrsc_pkg::MODE_BACK:     step_sel = step_back_r;
      default:                  step_sel = step_rotate_r;
    endcase
    // slowed wheel divisor numerator: (d - knee) times 4 straight, 9 back
    use_slow = (speed_r > dmrsc_pkg::SLOW_KNEE) && (d_abs > {1'b0, dmrsc_pkg::SLOW_KNEE});
    dm10     = 8'(d_abs - {1'b0, dmrsc_pkg::SLOW_KNEE});
    if (!use_slow) begin
      num_a = '0;
      den_a = W'(1);
    end else begin
      num_a = straight ? {2'b00, dm10, 2'b00} : ({1'b0, dm10, 3'b000} + {4'd0, dm10});
      den_a = {4'd0, speed_r - dmrsc_pkg::SLOW_KNEE};
    end
    // straight cap reduction divisor
    sd_eff  = (speed_div_r <= 8'd1) ? speed_r : speed_div_r;
    cap     = straight ? (speed_r - red_r) : speed_r;
    speed_s = {8'd0, speed_r};
    cap_s   = {8'd0, cap};
    capd_s  = cap_s - {7'd0, d_abs};
    st_s    = {8'd0, step_sel};
    stdiv_s = {8'd0, stdiv_r};
    r_lvl   = rotate ? lvl1_r : lvl2_r;
    l_lvl   = rotate ? lvl2_r : lvl1_r;
    // result word
    out_word                       = '0;
    out_word[0]                    = enabled_r;
    out_word[1]                    = pin_dir_r[3];
    out_word[2]                    = pin_dir_r[2];
    out_word[3]                    = pin_dir_r[1];
    out_word[4]                    = pin_dir_r[0];
    out_word[5 +: PWM_BITS]        = PWM_BITS'(pin_rpwm_r);
    out_word[5 + PWM_BITS +: PWM_BITS] = PWM_BITS'(pin_lpwm_r);
  end

  // next state
  always_comb begin
    state_nxt        = state_r;
    mode_started_nxt = mode_started_r;
    lvl1_nxt         = lvl1_r;
    lvl2_nxt         = lvl2_r;
    last_ramp_nxt    = last_ramp_r;
    pin_dir_nxt      = pin_dir_r;
    pin_rpwm_nxt     = pin_rpwm_r;
    pin_lpwm_nxt     = pin_lpwm_r;
    out_tvalid_nxt   = out_tvalid_r && !out_tready;
    out_tdata_nxt    = out_tdata_r;
    div_start_nxt    = 1'b0;
    mode_nxt         = mode_r;
    speed_nxt        = speed_r;
    delta_nxt        = delta_r;
    now_nxt          = now_r;
    enabled_nxt      = enabled_r;
    div_num_nxt      = div_num_r;
    div_den_nxt      = div_den_r;
    stdiv_nxt        = stdiv_r;
    red_nxt          = red_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser;
          speed_nxt = in_tdata[7:0];
          delta_nxt = in_tdata[16:8];
          now_nxt   = in_tdata[48:17];
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!mode_ok) begin
          // wait or unknown mode: bridges off, pins held
          mode_started_nxt = 4'd0;
          enabled_nxt      = 1'b0;
          state_nxt        = S_OUT;
        end else begin
          enabled_nxt      = 1'b1;
          mode_started_nxt = 4'(1) << mode_idx;
          state_nxt        = S_PINS;
          if (!mode_started_r[mode_idx]) begin
            lvl1_nxt = {8'd0, min_speed_r};
            lvl2_nxt = {8'd0, min_speed_r};
          end else if (ramp_due) begin
            last_ramp_nxt = now_r;
            if (rotate || delta_zero) begin
              lvl1_nxt = smin(lvl1_r + st_s, speed_s);
              lvl2_nxt = smin(lvl2_r + st_s, speed_s);
            end else begin
              div_num_nxt   = num_a;
              div_den_nxt   = den_a;
              div_start_nxt = 1'b1;
              state_nxt     = S_DIVA;
            end
          end
        end
      end
      S_DIVA: begin
        // slow divisor ready, now divide the step by it
        if (div_rsp.done) begin
          div_num_nxt   = {4'd0, step_sel};
          div_den_nxt   = div_rsp.quotient + W'(1);
          div_start_nxt = 1'b1;
          state_nxt     = S_DIVB;
        end
      end
      S_DIVB: begin
        if (div_rsp.done) begin
          stdiv_nxt = div_rsp.quotient[7:0];
          if (straight) begin
            div_num_nxt   = {4'd0, speed_r};
            div_den_nxt   = (sd_eff == 8'd0) ? W'(1) : {4'd0, sd_eff};
            div_start_nxt = 1'b1;
            state_nxt     = S_DIVC;
          end else begin
            red_nxt   = 8'd0;
            state_nxt = S_APPLY;
          end
        end
      end
      S_DIVC: begin
        if (div_rsp.done) begin
          red_nxt   = div_rsp.quotient[7:0];
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        // slowed wheel takes the divided step and the lower cap
        if (delta_neg) begin
          lvl1_nxt = smin(lvl1_r + stdiv_s, capd_s);
          lvl2_nxt = smin(lvl2_r + st_s, cap_s);
        end else begin
          lvl1_nxt = smin(lvl1_r + st_s, cap_s);
          lvl2_nxt = smin(lvl2_r + stdiv_s, capd_s);
        end
        state_nxt = S_PINS;
      end
      S_PINS: begin
        pin_dir_nxt  = dmrsc_pkg::dir_bits(mode_idx);
        pin_rpwm_nxt = sat_pwm(r_lvl);
        pin_lpwm_nxt = sat_pwm(l_lvl);
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = out_word;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      mode_started_r <= 4'd0;
      lvl1_r         <= '0;
      lvl2_r         <= '0;
      last_ramp_r    <= '0;
      pin_dir_r      <= 4'd0;
      pin_rpwm_r     <= 8'd0;
      pin_lpwm_r     <= 8'd0;
      out_tvalid_r   <= 1'b0;
      out_tdata_r    <= '0;
      div_start_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      mode_started_r <= mode_started_nxt;
      lvl1_r         <= lvl1_nxt;
      lvl2_r         <= lvl2_nxt;
      last_ramp_r    <= last_ramp_nxt;
      pin_dir_r      <= pin_dir_nxt;
      pin_rpwm_r     <= pin_rpwm_nxt;
      pin_lpwm_r     <= pin_lpwm_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
      out_tdata_r    <= out_tdata_nxt;
      div_start_r    <= div_start_nxt;
    end
  end

  // command and operand registers
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    speed_r   <= speed_nxt;
    delta_r   <= delta_nxt;
    now_r     <= now_nxt;
    enabled_r <= enabled_nxt;
    div_num_r <= div_num_nxt;
    div_den_r <= div_den_nxt;
    stdiv_r   <= stdiv_nxt;
    red_r     <= red_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: rtl/dmrsc_checker.sv
// port-level checks for the dual motor ramp and steer controller, bound to the top level
module dmrsc_checker #(
  parameter int PWM_BITS = 8,
  localparam int OutW = ((5 + 2 * PWM_BITS + 7) / 8) * 8
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_tvalid,
  input logic            in_tready,
  input logic            out_tvalid,
  input logic            out_tready,
  input logic [OutW-1:0] out_tdata
);

  // a stalled result transfer holds its data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one command at a time: no second transfer right after an accepted one
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  // an enabled result drives each bridge with opposite direction bits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (out_tdata[1] != out_tdata[2]) &&
                                   (out_tdata[3] != out_tdata[4]))
    else $error("enabled result with invalid bridge direction");

  // reset empties the result register
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dual_motor_ramp_steer_controller_core dmrsc_checker #(.PWM_BITS(PWM_BITS)) u_dmrsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
